FILE: hw/rtl/itc_pkg.sv
// Shared types and constants for the interval timer channel.
// No dependencies; used by itc_core and interval_timer_channel_unit.
`timescale 1ns / 1ps

package itc_pkg;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 32;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    localparam logic [1:0] PORT_DATA = 2'd0;
    localparam logic [1:0] PORT_CMD  = 2'd3;

    localparam logic [DATA_W-1:0] CMD_ARM_RATE = 8'h34;
    localparam logic [DATA_W-1:0] CMD_LATCH    = 8'h00;
    localparam logic [DATA_W-1:0] BYTE_IDLE    = 8'hff;

    localparam logic [COUNT_W-1:0] COUNT_TERMINAL = 16'd1;

    typedef struct packed {
        op_t               operation;
        logic [1:0]        port;
        logic [DATA_W-1:0] write_data;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               irq;
        logic [COUNT_W-1:0] current_count;
    } result_t;

endpackage

FILE: hw/rtl/interval_timer_channel_unit.sv
// Interval timer channel (mode-2 rate generator), streaming top level.
// Each item passes the input register, then the result register; the channel state updates
// as an item leaves the input register. Throughput: one item per cycle unless m_tready stalls.
// Reset: synchronous active-low aresetn clears both stage valids and all timer state to zero.
// Depends on itc_pkg and itc_core.
`timescale 1ns / 1ps

module interval_timer_channel_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [itc_pkg::S_TDATA_W-1:0]    s_tdata,   // port[1:0], write_data[9:2]
    input  logic [1:0]                       s_tuser,   // operation[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [itc_pkg::M_TDATA_W-1:0]    m_tdata    // read_data[7:0], irq[8], current_count[24:9]
);

    logic             in_valid_reg;
    itc_pkg::item_t   in_item_reg;
    logic             out_valid_reg;
    itc_pkg::result_t out_result_reg;
    itc_pkg::result_t core_result;
    logic             advance;
    logic             s_fire;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.operation  <= itc_pkg::op_t'(s_tuser);
            in_item_reg.port       <= s_tdata[1:0];
            in_item_reg.write_data <= s_tdata[9:2];
        end
    end

    itc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item_en (in_valid_reg && advance),
        .item    (in_item_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_result_reg.current_count, out_result_reg.irq,
                       out_result_reg.read_data};

endmodule

FILE: hw/rtl/itc_core.sv
// Timer channel state and the per-item update logic.
// Depends on itc_pkg.
`timescale 1ns / 1ps

module itc_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            item_en,
    input  itc_pkg::item_t  item,
    output itc_pkg::result_t result
);

    logic [itc_pkg::COUNT_W-1:0] counter_reg, counter_next;
    logic [itc_pkg::COUNT_W-1:0] reload_reg, reload_next;
    logic [itc_pkg::DATA_W-1:0]  low_hold_reg, low_hold_next;
    logic                        wr_high_reg, wr_high_next;
    logic                        rd_high_reg, rd_high_next;
    logic [itc_pkg::COUNT_W-1:0] latched_reg, latched_next;
    logic                        latch_valid_reg, latch_valid_next;
    logic                        running_reg, running_next;
    logic [itc_pkg::COUNT_W-1:0] read_value;
    logic [itc_pkg::COUNT_W-1:0] new_reload;

    always_comb begin
        counter_next     = counter_reg;
        reload_next      = reload_reg;
        low_hold_next    = low_hold_reg;
        wr_high_next     = wr_high_reg;
        rd_high_next     = rd_high_reg;
        latched_next     = latched_reg;
        latch_valid_next = latch_valid_reg;
        running_next     = running_reg;
        result.read_data = itc_pkg::BYTE_IDLE;
        result.irq       = 1'b0;
        read_value       = latch_valid_reg ? latched_reg : counter_reg;
        new_reload       = {item.write_data, low_hold_reg};

        unique case (item.operation)
            itc_pkg::OP_TICK: begin
                if (running_reg) begin
                    if (counter_reg == itc_pkg::COUNT_TERMINAL) begin
                        counter_next = reload_reg;
                        result.irq   = 1'b1;
                    end else begin
                        counter_next = counter_reg - itc_pkg::COUNT_W'(1);
                    end
                end
            end
            itc_pkg::OP_WRITE: begin
                if (item.port == itc_pkg::PORT_CMD) begin
                    if (item.write_data == itc_pkg::CMD_ARM_RATE) begin
                        running_next     = 1'b0;
                        wr_high_next     = 1'b0;
                        rd_high_next     = 1'b0;
                        latch_valid_next = 1'b0;
                    end else if (item.write_data == itc_pkg::CMD_LATCH) begin
                        if (!latch_valid_reg) begin
                            latched_next     = counter_reg;
                            latch_valid_next = 1'b1;
                        end
                    end
                end else if (item.port == itc_pkg::PORT_DATA) begin
                    if (!wr_high_reg) begin
                        low_hold_next = item.write_data;
                        wr_high_next  = 1'b1;
                    end else begin
                        reload_next  = new_reload;
                        wr_high_next = 1'b0;
                        if (!running_reg) begin
                            counter_next = new_reload;
                            running_next = 1'b1;
                        end
                    end
                end
            end
            itc_pkg::OP_READ: begin
                if (item.port == itc_pkg::PORT_DATA) begin
                    if (!rd_high_reg) begin
                        rd_high_next     = 1'b1;
                        result.read_data = read_value[itc_pkg::DATA_W-1:0];
                    end else begin
                        rd_high_next     = 1'b0;
                        latch_valid_next = 1'b0;
                        result.read_data = read_value[itc_pkg::COUNT_W-1:itc_pkg::DATA_W];
                    end
                end
            end
            default: begin
            end
        endcase

        result.current_count = counter_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg     <= '0;
            reload_reg      <= '0;
            low_hold_reg    <= '0;
            wr_high_reg     <= 1'b0;
            rd_high_reg     <= 1'b0;
            latched_reg     <= '0;
            latch_valid_reg <= 1'b0;
            running_reg     <= 1'b0;
        end else if (item_en) begin
            counter_reg     <= counter_next;
            reload_reg      <= reload_next;
            low_hold_reg    <= low_hold_next;
            wr_high_reg     <= wr_high_next;
            rd_high_reg     <= rd_high_next;
            latched_reg     <= latched_next;
            latch_valid_reg <= latch_valid_next;
            running_reg     <= running_next;
        end
    end

endmodule
